// ----- sv/conv3x3_rgb_stream_core_assert.svh -----
// ----------------------------------------------------------------------------
// conv3x3_rgb_stream_core assertion macros
// concurrent checks on the rising clock edge, masked while reset is active
// ----------------------------------------------------------------------------
`ifndef CONV3X3_RGB_STREAM_CORE_ASSERT_SVH
`define CONV3X3_RGB_STREAM_CORE_ASSERT_SVH

// condition holds at every edge
`define C3RGB_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define C3RGB_IMPLIES_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/c3rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// c3rgb_pkg
// shared types and constants of the 3x3 rgb stream convolution core
// ----------------------------------------------------------------------------
package c3rgb_pkg;

    // default geometry limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // field and register widths
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int COEF_W = 10;
    localparam int CFG_W  = 3 * COEF_W;
    localparam int FW_W   = 12;
    localparam int FH_W   = 13;
    localparam int IDX_W  = 3;

    // register reset values: 640 x 480 frame, blur kernel 1 2 1 / 2 4 2 / 1 2 1
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
    localparam logic [CFG_W-1:0] COEF_OUTER_RST   = 30'd1050625;
    localparam logic [CFG_W-1:0] COEF_MIDDLE_RST  = 30'd2101250;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pix_t;
    typedef pix_t [8:0]        win_t;
    typedef logic [CFG_W-1:0]  coef_row_t;
    typedef coef_row_t [2:0]   coef_set_t;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [IDX_W-1:0]
    {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MID     = 3'd3,
        REG_COEF_BOT     = 3'd4
    } reg_idx_t;

    // what travels with a window push: whether it completes an output pixel,
    // and which neighbours of that pixel lie inside the frame
    typedef struct packed
    {
        logic emit;
        logic frame_end;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } tap_info_t;

endpackage

// ----- sv/c3rgb_window.sv -----
// ----------------------------------------------------------------------------
// c3rgb_window
// two-row line store and 3x3 tap window, one column pushed per cycle while adv is high
// ----------------------------------------------------------------------------
module c3rgb_window #(
    parameter int MAX_WIDTH = c3rgb_pkg::DEF_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  push_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] push_col,
    input  c3rgb_pkg::pix_t       push_pix,
    input  c3rgb_pkg::tap_info_t  push_info,
    output logic                  tap_valid,
    output c3rgb_pkg::tap_info_t  tap_info,
    output c3rgb_pkg::win_t       win
);
    import c3rgb_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    // each word holds the pixel two rows up (high half) and one row up (low half)
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [2*PIX_W-1:0] wr_word;

    logic               p1_valid_reg;
    pix_t               p1_pix_reg;
    logic [COL_W-1:0]   p1_col_reg;
    tap_info_t          p1_info_reg;

    logic               s2_valid_reg;
    tap_info_t          s2_info_reg;
    win_t               win_reg;
    win_t               win_next;
    logic               wr_en;

    // write back the column: the row above moves up, the new pixel becomes the row above
    assign wr_en   = adv && p1_valid_reg;
    assign wr_word = {rd_reg[PIX_W-1:0], p1_pix_reg};

    // line store, read with forwarding of a write to the same column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[p1_col_reg] <= wr_word;
        end
        if (adv && push_valid)
        begin
            if (wr_en && (p1_col_reg == push_col))
            begin
                rd_reg <= wr_word;
            end
            else
            begin
                rd_reg <= line_mem[push_col];
            end
        end
    end

    // push stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= push_valid;
            s2_valid_reg <= p1_valid_reg && p1_info_reg.emit;
        end
    end

    // push stage payload
    always_ff @(posedge clk)
    begin
        if (adv && push_valid)
        begin
            p1_pix_reg  <= push_pix;
            p1_col_reg  <= push_col;
            p1_info_reg <= push_info;
        end
        if (adv && p1_valid_reg)
        begin
            s2_info_reg <= p1_info_reg;
            win_reg     <= win_next;
        end
    end

    // shift the window left by one column, new column on the right
    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = rd_reg[2*PIX_W-1:PIX_W];
        win_next[5] = rd_reg[PIX_W-1:0];
        win_next[8] = p1_pix_reg;
    end

    assign tap_valid = s2_valid_reg;
    assign tap_info  = s2_info_reg;
    assign win       = win_reg;

endmodule

// ----- sv/c3rgb_filter.sv -----
// ----------------------------------------------------------------------------
// c3rgb_filter
// per-channel 3x3 multiply, sum, clamp and output register
// ----------------------------------------------------------------------------
module c3rgb_filter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  tap_valid,
    input  c3rgb_pkg::tap_info_t  tap_info,
    input  c3rgb_pkg::win_t       win,
    input  c3rgb_pkg::coef_set_t  coefs,
    output logic                  out_valid,
    output c3rgb_pkg::chan_t      out_red,
    output c3rgb_pkg::chan_t      out_green,
    output c3rgb_pkg::chan_t      out_blue,
    output logic                  out_frame_end
);
    import c3rgb_pkg::*;

    localparam int PROD_W = CHAN_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 4;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    prod_t         prod_next [3][9];
    prod_t         prod_reg  [3][9];
    logic          p3_valid_reg;
    logic          p3_end_reg;
    sum_t          sum       [3];
    chan_t         res       [3];
    logic [2:0]    row_ok;
    logic [2:0]    col_ok;

    logic          out_valid_reg;
    chan_t         out_red_reg;
    chan_t         out_green_reg;
    chan_t         out_blue_reg;
    logic          out_end_reg;

    // negative gives 0, else sixteenths to integer, capped at 255
    function automatic chan_t clamp_chan(input sum_t s);
        sum_t q;
        q = s >>> 4;
        if (s < 0)
        begin
            return '0;
        end
        else if (q > sum_t'(255))
        begin
            return 8'd255;
        end
        return q[CHAN_W-1:0];
    endfunction

    assign row_ok = {tap_info.bot_ok, 1'b1, tap_info.top_ok};
    assign col_ok = {tap_info.right_ok, 1'b1, tap_info.left_ok};

    // masked products, taps outside the frame count as zero
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (row_ok[r] && col_ok[c])
                    begin
                        prod_next[ch][r*3 + c] = PROD_W'(
                            $signed({1'b0, win[r*3 + c][CHAN_W*(2-ch) +: CHAN_W]}) *
                            $signed(coefs[r][COEF_W*c +: COEF_W]));
                    end
                    else
                    begin
                        prod_next[ch][r*3 + c] = '0;
                    end
                end
            end
        end
    end

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p3_valid_reg  <= tap_valid;
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tap_valid)
        begin
            prod_reg   <= prod_next;
            p3_end_reg <= tap_info.frame_end;
        end
    end

    // sum and clamp
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int k = 0; k < 9; k++)
            begin
                sum[ch] = sum[ch] + SUM_W'(prod_reg[ch][k]);
            end
            res[ch] = clamp_chan(sum[ch]);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv && p3_valid_reg)
        begin
            out_red_reg   <= res[0];
            out_green_reg <= res[1];
            out_blue_reg  <= res[2];
            out_end_reg   <= p3_end_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_red       = out_red_reg;
    assign out_green     = out_green_reg;
    assign out_blue      = out_blue_reg;
    assign out_frame_end = out_end_reg;

endmodule

// ----- sv/conv3x3_rgb_stream_core.sv -----
// ----------------------------------------------------------------------------
// conv3x3_rgb_stream_core
// streaming 3x3 convolution of rgb pixels with programmable kernel
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_ready is high: pixels in raster order
// (op 0) and drain ticks (op 1). Output pixel n leaves once input pixel n+W+1 is
// in, or once the whole frame is in; after the last pixel, one drain tick per
// remaining output flushes the tail. A result passes from the window push that
// completes it (the push made with the transaction itself except where walk-ahead
// pushes follow) through the push, window, product and output registers. Frames
// of one row (or one column of two rows) stall the input at the end of the frame
// while the line store is walked forward one column per cycle unless the output
// stalls, the store's single read port setting that rate. Kernel rows use 10-bit
// signed sixteenths, left tap in the low bits; geometry writes restart the frame.
module conv3x3_rgb_stream_core #(
    parameter int MAX_WIDTH  = c3rgb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3rgb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  c3rgb_pkg::chan_t              in_red,
    input  c3rgb_pkg::chan_t              in_green,
    input  c3rgb_pkg::chan_t              in_blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output c3rgb_pkg::chan_t              out_red,
    output c3rgb_pkg::chan_t              out_green,
    output c3rgb_pkg::chan_t              out_blue,
    output logic                          frame_end,
    input  logic                          cfg_write,
    input  logic [c3rgb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [c3rgb_pkg::CFG_W-1:0]   cfg_data
);
    import c3rgb_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int LEAD_W = $clog2(MAX_WIDTH + 3);

    // configuration registers
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    coef_set_t        coef_reg;
    logic             geo_write;

    logic [EW_W-1:0]  eff_w;
    logic [ROW_W-1:0] eff_h;

    // position counters
    logic [COL_W-1:0]  in_col_reg,   in_col_next;
    logic [ROW_W-1:0]  in_row_reg,   in_row_next;
    logic [COL_W-1:0]  out_col_reg,  out_col_next;
    logic [ROW_W-1:0]  out_row_reg,  out_row_next;
    logic [COL_W-1:0]  push_col_reg, push_col_next;
    logic [LEAD_W-1:0] lead_reg,     lead_next;
    logic [1:0]        pend_reg,     pend_next;
    tap_info_t         info_reg,     info_next;

    // transaction decode
    logic              adv;
    logic              accept;
    logic              complete;
    logic              complete_after;
    logic              real_pix;
    logic              col_wrap;
    logic [ROW_W-1:0]  in_row_inc;
    logic [LEAD_W-1:0] lead_real;
    logic [LEAD_W-1:0] lead_target;
    logic [LEAD_W-1:0] lead_gap;
    logic              emit;
    logic              out_col_last;
    logic              out_row_last;
    logic [1:0]        push_cnt;
    tap_info_t         cur_info;

    // window pushes
    logic              push_acc;
    logic              push_pend;
    logic              push;
    logic              push_last;
    logic              push_emit;
    pix_t              push_pix;
    tap_info_t         push_info;

    logic              tap_valid;
    tap_info_t         tap_info;
    win_t              win;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            coef_reg[0]      <= COEF_OUTER_RST;
            coef_reg[1]      <= COEF_MIDDLE_RST;
            coef_reg[2]      <= COEF_OUTER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                REG_COEF_TOP:     coef_reg[0]      <= cfg_data;
                REG_COEF_MID:     coef_reg[1]      <= cfg_data;
                REG_COEF_BOT:     coef_reg[2]      <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign geo_write = cfg_write &&
        (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    // saturated geometry
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = EW_W'(1);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            eff_h = ROW_W'(1);
        end
        else if (32'(frame_height_reg) > MAX_HEIGHT)
        begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = ROW_W'(frame_height_reg);
        end
    end

    // handshake: stall while the output register is full and not taken, or while walking ahead
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv && (pend_reg == 2'd0);
    assign accept   = in_valid && in_ready;

    // transaction decode
    always_comb
    begin
        complete       = in_row_reg >= eff_h;
        real_pix       = (op == OP_PIXEL) && !complete;
        col_wrap       = (EW_W'(in_col_reg) + EW_W'(1)) >= eff_w;
        in_row_inc     = in_row_reg + ROW_W'(1);
        complete_after = complete || (real_pix && col_wrap && (in_row_inc >= eff_h));
        lead_real      = lead_reg + LEAD_W'(real_pix);
        lead_target    = LEAD_W'(eff_w) + LEAD_W'(2);
        lead_gap       = lead_target - lead_reg;
        emit           = complete_after || (lead_real >= lead_target);
        push_cnt       = emit ? lead_gap[1:0] : {1'b0, real_pix};

        out_col_last   = (EW_W'(out_col_reg) + EW_W'(1)) >= eff_w;
        out_row_last   = (out_row_reg + ROW_W'(1)) >= eff_h;

        cur_info.emit      = emit;
        cur_info.frame_end = out_col_last && out_row_last;
        cur_info.top_ok    = out_row_reg != '0;
        cur_info.bot_ok    = !out_row_last;
        cur_info.left_ok   = out_col_reg != '0;
        cur_info.right_ok  = !out_col_last;
    end

    // push issue: first push with the transaction, walk-ahead pushes after it
    always_comb
    begin
        push_acc  = accept && (push_cnt != 2'd0);
        push_pend = adv && (pend_reg != 2'd0);
        push      = push_acc || push_pend;
        push_last = push_acc ? (push_cnt == 2'd1) : (pend_reg == 2'd1);
        push_info = push_acc ? cur_info : info_reg;
        push_emit = push && push_last && push_info.emit;
        push_pix  = (push_acc && real_pix) ? {in_red, in_green, in_blue} : '0;
        push_info.emit = push_emit;
    end

    // counter next state
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        push_col_next = push_col_reg;
        lead_next     = lead_reg;
        pend_next     = pend_reg;
        info_next     = info_reg;

        if (geo_write)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            push_col_next = '0;
            lead_next     = '0;
            pend_next     = '0;
        end
        else
        begin
            if (accept)
            begin
                // input position
                if (real_pix)
                begin
                    if (col_wrap)
                    begin
                        in_col_next = '0;
                        in_row_next = in_row_inc;
                    end
                    else
                    begin
                        in_col_next = in_col_reg + COL_W'(1);
                    end
                end
                // output position, frame wrap after the last output
                if (emit)
                begin
                    if (cur_info.frame_end)
                    begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end
                    else if (out_col_last)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
                if (push_cnt != 2'd0)
                begin
                    pend_next = push_cnt - 2'd1;
                end
                info_next = cur_info;
            end
            else if (push_pend)
            begin
                pend_next = pend_reg - 2'd1;
            end

            // line store column and lead of pushes over outputs
            if (push)
            begin
                if (push_emit && push_info.frame_end)
                begin
                    push_col_next = '0;
                    lead_next     = '0;
                end
                else
                begin
                    if ((EW_W'(push_col_reg) + EW_W'(1)) >= eff_w)
                    begin
                        push_col_next = '0;
                    end
                    else
                    begin
                        push_col_next = push_col_reg + COL_W'(1);
                    end
                    if (!push_emit)
                    begin
                        lead_next = lead_reg + LEAD_W'(1);
                    end
                end
            end
        end
    end

    // counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            push_col_reg <= '0;
            lead_reg     <= '0;
            pend_reg     <= '0;
            info_reg     <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            push_col_reg <= push_col_next;
            lead_reg     <= lead_next;
            pend_reg     <= pend_next;
            info_reg     <= info_next;
        end
    end

    // line store and tap window
    c3rgb_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .push_valid (push),
        .push_col   (push_col_reg),
        .push_pix   (push_pix),
        .push_info  (push_info),
        .tap_valid  (tap_valid),
        .tap_info   (tap_info),
        .win        (win)
    );

    // kernel arithmetic and result register
    c3rgb_filter u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .tap_valid     (tap_valid),
        .tap_info      (tap_info),
        .win           (win),
        .coefs         (coef_reg),
        .out_valid     (out_valid),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .out_frame_end (frame_end)
    );

    // checks
`include "conv3x3_rgb_stream_core_assert.svh"

    `C3RGB_HOLDS(a_lead_bound, lead_reg <= lead_target,
        "push lead beyond one row plus two")
    `C3RGB_HOLDS(a_out_pos,
        (out_row_reg < eff_h) && ((EW_W'(out_col_reg)) < eff_w),
        "output position outside frame")
    `C3RGB_IMPLIES_NEXT(a_pend_walk, (pend_reg != 2'd0) && adv && !cfg_write,
        pend_reg == $past(pend_reg) - 2'd1, "walk-ahead push count did not step down")

endmodule
